// ===== sv/lcgbd_pkg.sv =====
// Shared types and constants for the 48-bit LCG with bounded draw.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcgbd_pkg;

  localparam int STATE_W = 48;
  localparam int MULT_W  = 35;
  localparam int RAND_W  = 31;

  localparam logic [MULT_W-1:0] LCG_MULT = 35'h5DEECE66D;
  localparam logic [3:0]        LCG_INC  = 4'hB;

  typedef enum logic [1:0] {
    OP_SEED = 2'd0,
    OP_BITS = 2'd1,
    OP_LONG = 2'd2,
    OP_INT  = 2'd3
  } op_t;

  // Status of a serial arithmetic unit.
  typedef struct packed {
    logic busy;
    logic done;
  } unit_stat_t;

endpackage

`default_nettype wire

// ===== sv/lcgbd_mul.sv =====
// Bit-serial constant multiplier: state * 0x5DEECE66D + 0xB, mod 2^48.
// One multiplier bit per cycle; depends on lcgbd_pkg.
`default_nettype none

module lcgbd_mul import lcgbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [STATE_W-1:0] operand,
  output unit_stat_t         stat,
  output logic [STATE_W-1:0] product
);

  localparam int CNT_W = $clog2(MULT_W);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [STATE_W-1:0] acc_r;
  logic [STATE_W-1:0] mcand_r;
  logic [MULT_W-1:0]  mplr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(MULT_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Shift-add over the constant's bits; the increment seeds the accumulator.
  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      acc_r   <= STATE_W'(LCG_INC);
      mcand_r <= operand;
      mplr_r  <= LCG_MULT;
    end else if (busy_r) begin
      if (mplr_r[0]) begin
        acc_r <= acc_r + mcand_r;
      end
      mcand_r <= {mcand_r[STATE_W-2:0], 1'b0};
      mplr_r  <= {1'b0, mplr_r[MULT_W-1:1]};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign product   = acc_r;

endmodule

`default_nettype wire

// ===== sv/lcgbd_div.sv =====
// Restoring bit-serial divider giving the remainder of a 31-bit draw.
// One quotient bit per cycle; depends on lcgbd_pkg.
`default_nettype none

module lcgbd_div import lcgbd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [RAND_W-1:0] dividend,
  input  logic [RAND_W-1:0] divisor,
  output unit_stat_t        stat,
  output logic [RAND_W-1:0] remainder
);

  localparam int CNT_W = $clog2(RAND_W);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [RAND_W-1:0] rem_r;
  logic [RAND_W-1:0] dvd_r;
  logic [RAND_W-1:0] dsr_r;
  logic [RAND_W:0]   trial;
  logic [RAND_W:0]   diff;
  logic [RAND_W-1:0] rem_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(RAND_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Bring down the next dividend bit, subtract when it fits.
  always_comb begin
    trial = {rem_r, dvd_r[RAND_W-1]};
    diff  = trial - {1'b0, dsr_r};
    if (trial >= {1'b0, dsr_r}) begin
      rem_nxt = diff[RAND_W-1:0];
    end else begin
      rem_nxt = trial[RAND_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dsr_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[RAND_W-2:0], 1'b0};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

// ===== sv/lcg48_random_with_bounded_draw_top.sv =====
// Top level of the 48-bit LCG with bounded draw: sequencer, state and output word.
// Depends on lcgbd_pkg, lcgbd_mul and lcgbd_div.
//
//   channel | ports                                         | direction
//   in      | in_valid/in_ready, in_op, in_seed_value,      | word in
//           | in_bit_count, in_upper_bound                  |
//   out     | out_valid/out_ready, out_value                | word out
//
// set_seed gives no word. Each advance runs the serial multiplier; next_bits and a power-of-two
// next_int load the output register after one advance, next_long after two. Other next_int
// bounds add a divide per attempt, and a rejected attempt repeats advance and divide.
// Reset clears the generator state to zero. A waiting output word does not block
// the next input word; the sequencer stalls only when a new result finds it full.
`default_nettype none

module lcg48_random_with_bounded_draw_top import lcgbd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_op,
  input  logic signed [63:0] in_seed_value,
  input  logic [5:0]         in_bit_count,
  input  logic [30:0]        in_upper_bound,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] out_value
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADV  = 4'b0010,
    S_DIV  = 4'b0100,
    S_FIN  = 4'b1000
  } fsm_t;

  fsm_t               fsm_r, fsm_nxt;
  logic [STATE_W-1:0] lcg_r, lcg_nxt;
  op_t                op_r, op_nxt;
  logic [5:0]         bits_r, bits_nxt;
  logic [RAND_W-1:0]  bound_r, bound_nxt;
  logic               pow2_r, pow2_nxt;
  logic [4:0]         shamt_r, shamt_nxt;
  logic               second_r, second_nxt;
  logic [31:0]        hi_r, hi_nxt;
  logic [RAND_W-1:0]  draw_r, draw_nxt;
  logic [63:0]        res_r, res_nxt;
  logic               out_valid_r;
  logic [63:0]        out_value_r;
  logic               out_load;

  logic               mul_go;
  logic [STATE_W-1:0] mul_opnd;
  unit_stat_t         mul_st;
  logic [STATE_W-1:0] prod;
  logic               div_go;
  unit_stat_t         div_st;
  logic [RAND_W-1:0]  rem;

  logic [31:0]        draw32;
  logic [31:0]        top_bits;
  logic [RAND_W-1:0]  r31;
  logic [31:0]        rej_sum;

  // Bit position of a power-of-two bound (zero for a zero bound).
  function automatic logic [4:0] bit_pos(input logic [RAND_W-1:0] b);
    logic [4:0] k;
    k = '0;
    for (int j = 0; j < RAND_W; j++) begin
      if (b[j]) begin
        k = k | 5'(j);
      end
    end
    return k;
  endfunction

  lcgbd_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_go),
    .operand (mul_opnd),
    .stat    (mul_st),
    .product (prod)
  );

  lcgbd_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_go),
    .dividend  (r31),
    .divisor   (bound_r),
    .stat      (div_st),
    .remainder (rem)
  );

  assign draw32   = prod[STATE_W-1:STATE_W-32];
  assign top_bits = draw32 >> (6'd32 - bits_r);
  assign r31      = prod[STATE_W-1:STATE_W-RAND_W];
  // Rejection when r - v + (bound - 1) passes 2^31 - 1.
  assign rej_sum  = {1'b0, draw_r} - {1'b0, rem} + {1'b0, bound_r} - 32'd1;

  assign in_ready = (fsm_r == S_IDLE);

  always_comb begin
    fsm_nxt    = fsm_r;
    lcg_nxt    = lcg_r;
    op_nxt     = op_r;
    bits_nxt   = bits_r;
    bound_nxt  = bound_r;
    pow2_nxt   = pow2_r;
    shamt_nxt  = shamt_r;
    second_nxt = second_r;
    hi_nxt     = hi_r;
    draw_nxt   = draw_r;
    res_nxt    = res_r;
    mul_go     = 1'b0;
    mul_opnd   = lcg_r;
    div_go     = 1'b0;
    out_load   = 1'b0;
    unique case (fsm_r)
      S_IDLE: begin
        if (in_valid) begin
          op_nxt     = op_t'(in_op);
          bits_nxt   = (in_bit_count > 6'd32) ? 6'd32 : in_bit_count;
          bound_nxt  = in_upper_bound;
          pow2_nxt   = ((in_upper_bound & (in_upper_bound - 31'd1)) == '0);
          shamt_nxt  = 5'd31 - bit_pos(in_upper_bound);
          second_nxt = 1'b0;
          if (op_t'(in_op) == OP_SEED) begin
            lcg_nxt = STATE_W'(in_seed_value ^ 64'(LCG_MULT));
          end else begin
            mul_go  = 1'b1;
            fsm_nxt = S_ADV;
          end
        end
      end
      S_ADV: begin
        if (mul_st.done) begin
          lcg_nxt = prod;
          unique case (op_r)
            OP_BITS: begin
              res_nxt = {{32{top_bits[31]}}, top_bits};
              fsm_nxt = S_FIN;
            end
            OP_LONG: begin
              if (!second_r) begin
                // Hold the high word and advance again from the fresh state.
                hi_nxt     = draw32;
                second_nxt = 1'b1;
                mul_go     = 1'b1;
                mul_opnd   = prod;
              end else begin
                res_nxt = {hi_r + {32{draw32[31]}}, draw32};
                fsm_nxt = S_FIN;
              end
            end
            OP_INT: begin
              draw_nxt = r31;
              if (pow2_r) begin
                res_nxt = {33'd0, r31 >> shamt_r};
                fsm_nxt = S_FIN;
              end else begin
                div_go  = 1'b1;
                fsm_nxt = S_DIV;
              end
            end
            default: begin
              fsm_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_DIV: begin
        if (div_st.done) begin
          if (rej_sum[31]) begin
            // Drop this draw and take another from the advanced state.
            mul_go  = 1'b1;
            fsm_nxt = S_ADV;
          end else begin
            res_nxt = {33'd0, rem};
            fsm_nxt = S_FIN;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_load = 1'b1;
          fsm_nxt  = S_IDLE;
        end
      end
      default: begin
        fsm_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fsm_r       <= S_IDLE;
      lcg_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      fsm_r <= fsm_nxt;
      lcg_r <= lcg_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r     <= op_nxt;
    bits_r   <= bits_nxt;
    bound_r  <= bound_nxt;
    pow2_r   <= pow2_nxt;
    shamt_r  <= shamt_nxt;
    second_r <= second_nxt;
    hi_r     <= hi_nxt;
    draw_r   <= draw_nxt;
    res_r    <= res_nxt;
    if (out_load) begin
      out_value_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = out_value_r;

`ifndef SYNTHESIS
  a_idle_units_free: assert property (@(posedge clk) disable iff (!rst_n)
    (fsm_r == S_IDLE) |-> (!mul_st.busy && !div_st.busy))
    else $error("arithmetic unit busy while sequencer idle");

  a_mul_done_in_adv: assert property (@(posedge clk) disable iff (!rst_n)
    mul_st.done |-> (fsm_r == S_ADV))
    else $error("multiplier finished outside advance state");

  a_div_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    div_st.done |-> (fsm_r == S_DIV))
    else $error("divider finished outside divide state");

  a_load_frees_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (!out_valid_r || out_ready))
    else $error("output word overwritten before it was taken");
`endif

endmodule

`default_nettype wire

// ===== sim/tb.sv =====
// Testbench for lcg48_random_with_bounded_draw_top: directed and random seed/draw words,
// with a predicting scoreboard checking every output word in order.
// Depends on lcgbd_pkg and the RTL of the block only.
module tb;
  import lcgbd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 200;
  localparam int RANDOM_WORDS = 600;

  class lcg_draw_checker;
    logic [47:0] gen_state;
    logic [63:0] drawn_values[$];
    int failures;

    function new();
      gen_state = '0;
      failures = 0;
    endfunction

    // append an expected word at the tail
    function void queue_value(logic [63:0] v);
      drawn_values.insert(drawn_values.size(), v);
    endfunction

    // advance once, return the top bits sign-extended from bit 31
    function logic [63:0] draw_top(int unsigned bits);
      logic [63:0] top;
      gen_state = gen_state * LCG_MULT + LCG_INC;
      if (bits == 0) return '0;
      top = {16'b0, gen_state} >> (48 - bits);
      top = top & 64'h0000_0000_FFFF_FFFF;
      if (top[31]) top[63:32] = '1;
      return top;
    endfunction

    function logic [63:0] bounded_draw(logic [30:0] bound);
      logic [63:0] b;
      logic [63:0] r;
      logic [63:0] v;
      b = {33'b0, bound};
      // zero bound falls into the power-of-two path
      if ((b & (b - 64'd1)) == 64'd0) begin
        r = draw_top(31);
        return (b * r) >> 31;
      end
      do begin
        r = draw_top(31);
        v = r % b;
      end while (r - v + (b - 64'd1) > 64'd2147483647);
      return v;
    endfunction

    function void note_word(op_t op, logic [63:0] seed, logic [5:0] bits,
                            logic [30:0] bound);
      int unsigned n;
      logic [63:0] hi;
      logic [63:0] lo;
      case (op)
        OP_SEED: gen_state = seed[47:0] ^ LCG_MULT;
        OP_BITS: begin
          n = 32'(bits);
          if (n > 32) n = 32;
          queue_value(draw_top(n));
        end
        OP_LONG: begin
          hi = draw_top(32);
          lo = draw_top(32);
          queue_value((hi << 32) + lo);
        end
        default: queue_value(bounded_draw(bound));
      endcase
    endfunction

    function void flag(string what, logic [63:0] want, logic [63:0] got);
      failures++;
      if (failures <= 10)
        $display("%0t ns: %s: expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_word(logic [63:0] got);
      logic [63:0] want;
      if (drawn_values.size() == 0) begin
        flag("output word with nothing pending", 'x, got);
        return;
      end
      want = drawn_values.pop_front();
      if (got !== want) flag("value mismatch", want, got);
    endfunction
  endclass

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_op;
  logic signed [63:0] in_seed_value;
  logic [5:0]         in_bit_count;
  logic [30:0]        in_upper_bound;
  logic               out_valid;
  logic               out_ready;
  logic signed [63:0] out_value;

  lcg_draw_checker sb;
  bit tx_steady;
  bit rx_steady;

  lcg48_random_with_bounded_draw_top u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_seed_value  (in_seed_value),
    .in_bit_count   (in_bit_count),
    .in_upper_bound (in_upper_bound),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_value      (out_value)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_word(input op_t op, input logic [63:0] seed,
                           input logic [5:0] bits, input logic [30:0] bound);
    int gap;
    gap = tx_steady ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_op          = op;
    in_seed_value  = seed;
    in_bit_count   = bits;
    in_upper_bound = bound;
    in_valid       = 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
  endtask

  task automatic send_random_word();
    int sel;
    int kind;
    logic [63:0] seed;
    logic [5:0]  bits;
    logic [30:0] bound;
    // unused fields carry random content too
    seed  = {$urandom, $urandom};
    bits  = 6'($urandom);
    bound = 31'($urandom);
    sel = $urandom_range(0, 99);
    if (sel < 10) begin
      send_word(OP_SEED, seed, bits, bound);
    end else if (sel < 35) begin
      if ($urandom_range(0, 99) < 85) bits = 6'($urandom_range(1, 32));
      send_word(OP_BITS, seed, bits, bound);
    end else if (sel < 55) begin
      send_word(OP_LONG, seed, bits, bound);
    end else begin
      kind = $urandom_range(0, 9);
      case (kind)
        0: bound = 31'd1 << $urandom_range(0, 30);
        1: bound = 31'($urandom_range(1, 16));
        2, 3: bound = 31'((32'd1 << 30) + $urandom_range(1, 1 << 29));
        4: if ($urandom_range(0, 9) == 0) bound = '0;
        5, 6: bound = 31'($urandom_range(1, 2147483647));
        default: ;
      endcase
      send_word(OP_INT, seed, bits, bound);
    end
  endtask

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_word(op_t'(in_op), in_seed_value, in_bit_count, in_upper_bound);
      if (out_valid && out_ready)
        sb.check_word(out_value);
    end
  end

  initial begin : rx_side
    int hold;
    out_ready = 1'b0;
    rx_steady = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 79) == 0) rx_steady = !rx_steady;
      if (rx_steady) begin
        out_ready = 1'b1;
      end else begin
        hold = pick_gap();
        if (hold == 0) begin
          out_ready = 1'b1;
        end else begin
          out_ready = 1'b0;
          repeat (hold - 1) @(negedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle = 0;
      else idle++;
    end
    $display("stalled for %0d cycles with no word moving", IDLE_LIMIT);
    $display("CHECK FAILED");
    $finish;
  end

  initial begin : stimulus
    sb = new();
    tx_steady      = 1'b0;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_SEED;
    in_seed_value  = '0;
    in_bit_count   = '0;
    in_upper_bound = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // draws from the unseeded state first
    send_word(OP_BITS, 64'h0, 6'd32, 31'd0);
    send_word(OP_INT,  64'h0, 6'd0,  31'd0);
    send_word(OP_SEED, 64'h0, 6'd0,  31'd0);
    send_word(OP_BITS, 64'h0, 6'd0,  31'd0);
    send_word(OP_BITS, 64'h0, 6'd1,  31'd0);
    send_word(OP_BITS, 64'h0, 6'd31, 31'd0);
    send_word(OP_BITS, 64'h0, 6'd33, 31'd0);
    send_word(OP_BITS, 64'h0, 6'd63, 31'd0);
    send_word(OP_LONG, 64'h0, 6'd0,  31'd0);
    send_word(OP_SEED, 64'hFFFF_FFFF_FFFF_FFFF, 6'd63, 31'h7FFF_FFFF);
    send_word(OP_INT,  64'h0, 6'd0,  31'd1);
    send_word(OP_INT,  64'h0, 6'd0,  31'h4000_0000);
    send_word(OP_INT,  64'h0, 6'd0,  31'h7FFF_FFFF);
    // just above a power of two: about half of the draws are rejected
    repeat (3) send_word(OP_INT, 64'h0, 6'd0, 31'h4000_0001);
    send_word(OP_INT,  64'h0, 6'd0,  31'd3);
    send_word(OP_INT,  64'h0, 6'd0,  31'd7);
    send_word(OP_SEED, 64'h8000_0000_0000_0000, 6'd0, 31'd0);
    send_word(OP_LONG, 64'h0, 6'd0,  31'd0);
    send_word(OP_SEED, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0, 31'd0);
    send_word(OP_BITS, 64'h0, 6'd32, 31'd0);
    send_word(OP_INT,  64'h0, 6'd0,  31'd5);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if ($urandom_range(0, 49) == 0) tx_steady = !tx_steady;
      send_random_word();
    end
    in_valid = 1'b0;

    while (sb.drawn_values.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (sb.failures == 0 && sb.drawn_values.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
